### rtl/core/jbnd_pkg.sv
// ----------------------------------------------------------------------------
// jbnd_pkg
// Shared widths, framing codes and types for the no-device responder.
// ----------------------------------------------------------------------------
package jbnd_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W  = 6;
   localparam int SKIP_W = LEN_W + 1;

   localparam int RAM_IMAGE_BYTES_DEF = 64;

   localparam logic [BYTE_W-1:0] CODE_SKIP       = 8'h00;
   localparam logic [BYTE_W-1:0] CODE_RESET      = 8'hFD;
   localparam logic [BYTE_W-1:0] CODE_END        = 8'hFE;
   localparam logic [BYTE_W-1:0] CODE_PAD        = 8'hFF;
   localparam logic [BYTE_W-1:0] ERR_FIELD       = 8'hC0;
   localparam logic [BYTE_W-1:0] ERR_NO_RESPONSE = 8'h80;
   localparam logic [BYTE_W-1:0] LEN_FIELD       = 8'h3F;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              is_header;
      logic              was_flagged;
   } result_type;

endpackage

### rtl/core/joybus_no_device_responder.sv
// ----------------------------------------------------------------------------
// joybus_no_device_responder
// Passes a controller command image through byte by byte and answers every
// command block with the no-response code.
//
//   channel  | direction | ports
//   ---------+-----------+--------------------------------------------------
//   request  | in        | req_valid, req_ready, req_in_byte
//   response | out       | rsp_valid, rsp_ready, rsp_out_byte,
//            |           | rsp_is_header, rsp_was_flagged
//
// One request is taken per cycle while the output is not stalled. Its
// response moves from the input register into the output register, from
// which it is presented. The framing state is updated as a request moves
// from the input register into the output register. A stalled output holds
// the output register, and the input register still takes one more
// request. Reset clears all framing state and empties both registers.
// ----------------------------------------------------------------------------
module joybus_no_device_responder #(
   parameter int RAM_IMAGE_BYTES = jbnd_pkg::RAM_IMAGE_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [jbnd_pkg::BYTE_W-1:0] req_in_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [jbnd_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                        rsp_is_header,
   output logic                        rsp_was_flagged
);

   logic                        in_valid_ff;
   logic [jbnd_pkg::BYTE_W-1:0] in_byte_ff;
   logic                        out_valid_ff;
   jbnd_pkg::result_type        out_ff;
   jbnd_pkg::result_type        result;
   logic                        advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   jbnd_frame_parser #(
      .RAM_IMAGE_BYTES(RAM_IMAGE_BYTES)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .in_byte(in_byte_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_in_byte;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_ff.out_byte;
   assign rsp_is_header   = out_ff.is_header;
   assign rsp_was_flagged = out_ff.was_flagged;

endmodule

### rtl/core/jbnd_frame_parser.sv
// ----------------------------------------------------------------------------
// jbnd_frame_parser
// Walks the channel framing of the command image one byte per step and
// marks each receive size byte with the no-response code.
// ----------------------------------------------------------------------------
module jbnd_frame_parser #(
   parameter int RAM_IMAGE_BYTES = jbnd_pkg::RAM_IMAGE_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [jbnd_pkg::BYTE_W-1:0]    in_byte,
   output jbnd_pkg::result_type           result
);

   localparam int POS_W = $clog2(RAM_IMAGE_BYTES);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(RAM_IMAGE_BYTES - 1);

   localparam logic [1:0] PHASE_HEADER  = 2'd0;
   localparam logic [1:0] PHASE_RXSIZE  = 2'd1;
   localparam logic [1:0] PHASE_SKIP    = 2'd2;
   localparam logic [1:0] PHASE_STOPPED = 2'd3;

   logic [POS_W-1:0]            position_ff;
   logic [POS_W-1:0]            position_in;
   logic [1:0]                  phase_ff;
   logic [1:0]                  phase_in;
   logic [jbnd_pkg::LEN_W-1:0]  tx_length_ff;
   logic [jbnd_pkg::LEN_W-1:0]  tx_length_in;
   logic [jbnd_pkg::SKIP_W-1:0] skip_ff;
   logic [jbnd_pkg::SKIP_W-1:0] skip_in;
   logic [jbnd_pkg::SKIP_W-1:0] skip_next;
   logic                        last;

   assign last = (position_ff == POS_LAST);

   always_comb begin
      result.out_byte    = in_byte;
      result.is_header   = 1'b0;
      result.was_flagged = 1'b0;
      phase_in           = phase_ff;
      tx_length_in       = tx_length_ff;
      skip_in            = skip_ff;
      skip_next          = skip_ff;
      case (phase_ff)
         PHASE_HEADER: begin
            if (!last) begin
               if (in_byte == jbnd_pkg::CODE_END) begin
                  phase_in = PHASE_STOPPED;
               end else if (!(in_byte inside {jbnd_pkg::CODE_PAD, jbnd_pkg::CODE_SKIP,
                                              jbnd_pkg::CODE_RESET})) begin
                  result.is_header = 1'b1;
                  tx_length_in     = in_byte[jbnd_pkg::LEN_W-1:0];
                  phase_in         = PHASE_RXSIZE;
               end
            end
         end
         PHASE_RXSIZE: begin
            result.out_byte    = (in_byte & ~jbnd_pkg::ERR_FIELD) | jbnd_pkg::ERR_NO_RESPONSE;
            result.was_flagged = 1'b1;
            skip_in = {1'b0, tx_length_ff} + {1'b0, in_byte[jbnd_pkg::LEN_W-1:0]};
            phase_in = (skip_in == '0) ? PHASE_HEADER : PHASE_SKIP;
         end
         PHASE_SKIP: begin
            if (skip_ff != '0) begin
               skip_next = skip_ff - 1'b1;
            end
            skip_in = skip_next;
            if (skip_next == '0) begin
               phase_in = PHASE_HEADER;
            end
         end
         default: begin
         end
      endcase
      position_in = position_ff + 1'b1;
      if (last) begin
         position_in  = '0;
         phase_in     = PHASE_HEADER;
         tx_length_in = '0;
         skip_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         phase_ff     <= PHASE_HEADER;
         tx_length_ff <= '0;
         skip_ff      <= '0;
      end else if (step) begin
         position_ff  <= position_in;
         phase_ff     <= phase_in;
         tx_length_ff <= tx_length_in;
         skip_ff      <= skip_in;
      end
   end

endmodule
